// ===== design/tilted_wave_pattern_generator_unit_macros.svh =====
// Assertion macros for the tilted wave pattern generator checker.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef TILTED_WAVE_PATTERN_GENERATOR_UNIT_MACROS_SVH
`define TILTED_WAVE_PATTERN_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWPG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tilted wave generator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TWPG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tilted wave generator check failed");

`endif

// ===== design/twpg_pkg.sv =====
// Shared types, constants and the sine table of the tilted wave pattern generator.
// Depends on nothing; the front, queue, back and top refer to it by scoped names.
package twpg_pkg;

	localparam int SINE_DEPTH = 1024;
	localparam int MAX_DIM    = 4096;

	// Width of a clamped coordinate and of width-1 / height-1.
	localparam int DW   = $clog2(MAX_DIM);
	localparam int SIW  = $clog2(SINE_DEPTH);
	localparam int NUMW = 2 * DW + 16;
	localparam int HALF = NUMW / 2;
	localparam int QW   = 25;
	localparam int RW   = 2 * DW + 33;

	localparam logic [16:0] ONE_Q16  = 17'h10000;
	localparam logic [16:0] HALF_Q16 = 17'h08000;

	localparam logic [1:0] SHAPE_SINE   = 2'd0;
	localparam logic [1:0] SHAPE_SQUARE = 2'd1;
	localparam logic [1:0] SHAPE_TRI    = 2'd2;
	localparam logic [1:0] SHAPE_SAW    = 2'd3;

	localparam logic [2:0] REG_FREQ   = 3'd0;
	localparam logic [2:0] REG_PHASE  = 3'd1;
	localparam logic [2:0] REG_TILT   = 3'd2;
	localparam logic [2:0] REG_SHAPE  = 3'd3;
	localparam logic [2:0] REG_WIDTH  = 3'd4;
	localparam logic [2:0] REG_HEIGHT = 3'd5;
	localparam logic [2:0] REG_FRAME  = 3'd6;

	// Configuration after clamping, as seen by the front and back.
	typedef struct packed {
		logic signed [15:0] freq;
		logic [15:0]        start_phase;
		logic [16:0]        tilt;
		logic [1:0]         shape;
		logic [DW-1:0]      wm1;
		logic [DW-1:0]      hm1;
		logic [15:0]        frame;
	} cfg_t;

	// One classified pixel, passed from front to back.
	typedef struct packed {
		logic [DW-1:0] x;
		logic [DW-1:0] ry;
		logic [16:0]   xa;
		logic [16:0]   ya;
		logic          rp;
		logic          last;
	} item_t;

	typedef logic signed [15:0] sine_lut_t [SINE_DEPTH];

	// Q15 sine of entry idx, evaluated at elaboration only.
	function automatic logic signed [15:0] sine_entry(input longint unsigned idx);
		longint unsigned one_q30, half_pi, turn, r, x, x2, acc, s, q;
		int quad;
		one_q30 = 64'd1073741824;
		half_pi = 64'd1686629713;
		turn = (idx << 32) / SINE_DEPTH;
		quad = int'((turn >> 30) & 64'd3);
		r = turn & (one_q30 - 64'd1);
		if (quad % 2 == 1) begin
			r = one_q30 - r;
		end
		x = (r * half_pi) >> 30;
		x2 = (x * x) >> 30;
		// Horner form of the odd Taylor series, highest term first.
		acc = one_q30;
		acc = one_q30 - ((x2 * acc) >> 30) / 64'd156;
		acc = one_q30 - ((x2 * acc) >> 30) / 64'd110;
		acc = one_q30 - ((x2 * acc) >> 30) / 64'd72;
		acc = one_q30 - ((x2 * acc) >> 30) / 64'd42;
		acc = one_q30 - ((x2 * acc) >> 30) / 64'd20;
		acc = one_q30 - ((x2 * acc) >> 30) / 64'd6;
		s = (x * acc) >> 30;
		q = (s + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		if (quad >= 2) begin
			return -$signed(q[15:0]);
		end
		return $signed(q[15:0]);
	endfunction

	function automatic sine_lut_t build_sine_lut();
		sine_lut_t t;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			t[k] = sine_entry(longint'(k));
		end
		return t;
	endfunction

	localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

// ===== design/twpg_front.sv =====
// Front of the tilted wave pattern generator: clamps a pixel coordinate and
// classifies the tilt into its segment weights. Depends on twpg_pkg.
module twpg_front (
	input  twpg_pkg::cfg_t  cfg,
	input  logic [11:0]     row,
	input  logic [11:0]     column,
	output twpg_pkg::item_t item
);

	logic [twpg_pkg::DW-1:0] x, y;
	logic [16:0] u;
	logic        flip;

	always_comb begin
		x = (column > cfg.wm1) ? cfg.wm1 : twpg_pkg::DW'(column);
		y = (row > cfg.hm1) ? cfg.hm1 : twpg_pkg::DW'(row);
		u = twpg_pkg::ONE_Q16 - cfg.tilt;
		if (u <= 17'd16384) begin
			item.xa = {u[14:0], 2'b00};
			item.ya = twpg_pkg::ONE_Q16 - item.xa;
			item.rp = 1'b0;
			flip = 1'b0;
		end else if (u <= 17'd32768) begin
			item.ya = 17'({u - 17'd16384, 2'b00});
			item.xa = twpg_pkg::ONE_Q16 - item.ya;
			item.rp = 1'b0;
			flip = 1'b1;
		end else if (u <= 17'd49152) begin
			item.xa = 17'({u - 17'd32768, 2'b00});
			item.ya = twpg_pkg::ONE_Q16 - item.xa;
			item.rp = 1'b1;
			flip = 1'b0;
		end else begin
			item.ya = 17'({u - 17'd49152, 2'b00});
			item.xa = twpg_pkg::ONE_Q16 - item.ya;
			item.rp = 1'b1;
			flip = 1'b1;
		end
		item.x = x;
		item.ry = flip ? (cfg.hm1 - y) : y;
		item.last = (x == cfg.wm1);
	end

endmodule

// ===== design/twpg_queue.sv =====
// Two-entry queue that decouples the front from the back.
// Depends on twpg_pkg for the item type.
module twpg_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  twpg_pkg::item_t wr_data,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output twpg_pkg::item_t rd_data
);

	twpg_pkg::item_t entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== design/twpg_back.sv =====
// Back of the tilted wave pattern generator: phase arithmetic, serial divider,
// wave shaping and the result register. Depends on twpg_pkg.
module twpg_back (
	input  logic               clk,
	input  logic               arst_n,
	input  twpg_pkg::cfg_t     cfg,
	input  logic               q_empty,
	input  twpg_pkg::item_t    q_data,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic signed [15:0] sample
);

	localparam int DW   = twpg_pkg::DW;
	localparam int NUMW = twpg_pkg::NUMW;
	localparam int HALF = twpg_pkg::HALF;
	localparam int QW   = twpg_pkg::QW;
	localparam int RW   = twpg_pkg::RW;
	localparam int SIW  = twpg_pkg::SIW;
	localparam int PW   = 16 + SIW + 1;
	localparam int CW   = $clog2(QW);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL1  = 4'd1;
	localparam logic [3:0] ST_MUL2  = 4'd2;
	localparam logic [3:0] ST_MUL3  = 4'd3;
	localparam logic [3:0] ST_MUL4  = 4'd4;
	localparam logic [3:0] ST_MUL5  = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_PHASE = 4'd7;
	localparam logic [3:0] ST_LOOK  = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	logic [3:0] state_q;
	twpg_pkg::item_t item_q;

	logic [DW+16:0]     pa_q, pb_q;
	logic [2*DW-1:0]    wh_q;
	logic [NUMW-1:0]    ta_q, tb_q, num_q;
	logic [HALF+15:0]   mlo_q, mhi_q;
	logic [RW-1:0]      rem_q, div_q;
	logic [QW-1:0]      quo_q;
	logic [CW-1:0]      cnt_q;
	logic [23:0]        fp1_q, fp2_q;
	logic [15:0]        held_q;
	logic               ready_q;
	logic [15:0]        p16_q;
	logic signed [15:0] sine_q;
	logic signed [16:0] saw_note_q;
	logic               out_valid_q;
	logic signed [15:0] sample_q;

	// Combinational helpers
	logic [2*DW+16:0]   ta_full, tb_full;
	logic [15:0]        absf;
	logic signed [32:0] fnf;
	logic [23:0]        mult24;
	logic [47:0]        fpm;
	logic [23:0]        fsum;
	logic [RW-1:0]      rem_sub;
	logic               take;
	logic [15:0]        contrib;
	logic [PW-1:0]      iprod;
	logic [SIW-1:0]     sidx;
	logic signed [15:0] v;
	logic [16:0]        absv;
	logic signed [16:0] tri_v;
	logic signed [17:0] lo, hi, sa, sb, res;
	logic               store, out_free;
	logic signed [15:0] res_sat;
	logic               t_edge, t_mid, t_low, t_high;

	assign empty    = !out_valid_q;
	assign sample   = sample_q;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign out_free = !out_valid_q || pop;

	always_comb begin
		ta_full = pa_q * cfg.hm1;
		tb_full = pb_q * cfg.wm1;
		absf    = cfg.freq[15] ? 16'(-cfg.freq) : cfg.freq;
		fnf     = $signed({1'b0, cfg.frame}) * cfg.freq;
		if (cfg.tilt <= twpg_pkg::HALF_Q16) begin
			mult24 = 24'd65536 - {5'd0, cfg.tilt, 2'b00};
		end else begin
			mult24 = 24'd196608 - {5'd0, cfg.tilt, 2'b00};
		end
		fpm     = fp1_q * mult24;
		fsum    = fp2_q + {cfg.start_phase, 8'h00} + 24'd128;
		rem_sub = rem_q - div_q;
		take    = (rem_q >= div_q);
		contrib = cfg.freq[15] ? (16'd0 - quo_q[15:0]) : quo_q[15:0];
		iprod   = PW'(p16_q) * PW'(twpg_pkg::SINE_DEPTH);
		sidx    = SIW'(iprod >> 16);
	end

	// Wave shaping on the final phase.
	always_comb begin
		v      = $signed(p16_q - 16'd16384);
		absv   = v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
		tri_v  = $signed({absv[15:0], 1'b0}) - 17'sd32768;
		lo     = 18'(tri_v >>> 1) - 18'sd16384;
		hi     = 18'sd16384 - 18'(tri_v >>> 1);
		if (tri_v <= saw_note_q) begin
			sa = lo;
			sb = hi;
		end else begin
			sa = hi;
			sb = lo;
		end
		t_edge = (cfg.tilt == 17'd0) || (cfg.tilt == twpg_pkg::ONE_Q16);
		t_mid  = (cfg.tilt == twpg_pkg::HALF_Q16);
		t_low  = (cfg.tilt != 17'd0) && (cfg.tilt < twpg_pkg::HALF_Q16);
		t_high = (cfg.tilt > twpg_pkg::HALF_Q16) && (cfg.tilt < twpg_pkg::ONE_Q16);
		store  = 1'b0;
		case (cfg.shape)
			twpg_pkg::SHAPE_SINE: begin
				res = 18'(sine_q);
			end
			twpg_pkg::SHAPE_SQUARE: begin
				res = sine_q[15] ? -18'sd32768 : 18'sd32767;
			end
			twpg_pkg::SHAPE_TRI: begin
				res = 18'(tri_v);
			end
			default: begin
				if (t_edge && item_q.last) begin
					store = 1'b1;
					res = sa;
				end else if (t_mid && item_q.last) begin
					store = 1'b1;
					res = sb;
				end else if (t_low) begin
					store = 1'b1;
					res = sb;
				end else if (t_high) begin
					store = 1'b1;
					res = sa;
				end else begin
					res = sa;
				end
			end
		endcase
		if (res > 18'sd32767) begin
			res_sat = 16'sd32767;
		end else if (res < -18'sd32768) begin
			res_sat = -16'sd32768;
		end else begin
			res_sat = res[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ready_q     <= 1'b0;
			held_q      <= 16'd0;
			saw_note_q  <= 17'sd0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces one that is popped in the same cycle.
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: begin
					if (!ready_q) begin
						held_q  <= fsum[23:8];
						ready_q <= 1'b1;
					end
					state_q <= ST_MUL4;
				end
				ST_MUL4: state_q <= ST_MUL5;
				ST_MUL5: state_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_PHASE;
					end
				end
				ST_PHASE: state_q <= ST_LOOK;
				ST_LOOK:  state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						if (store) begin
							saw_note_q <= tri_v;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= q_data;
			end
			ST_MUL1: begin
				pa_q  <= item_q.x * item_q.xa;
				pb_q  <= item_q.ry * item_q.ya;
				wh_q  <= cfg.wm1 * cfg.hm1;
				fp1_q <= fnf[23:0];
			end
			ST_MUL2: begin
				ta_q  <= ta_full[NUMW-1:0];
				tb_q  <= tb_full[NUMW-1:0];
				fp2_q <= fpm[23:0];
			end
			ST_MUL3: begin
				num_q <= ta_q + tb_q;
			end
			ST_MUL4: begin
				mlo_q <= num_q[HALF-1:0] * absf;
				mhi_q <= num_q[NUMW-1:HALF] * absf;
			end
			ST_MUL5: begin
				rem_q <= (RW'(mhi_q) << HALF) + RW'(mlo_q) + (RW'(wh_q) << 7);
				div_q <= RW'(wh_q) << (8 + QW - 1);
				cnt_q <= CW'(QW - 1);
			end
			ST_DIV: begin
				if (take) begin
					rem_q <= rem_sub;
				end
				quo_q <= {quo_q[QW-2:0], take};
				div_q <= div_q >> 1;
				cnt_q <= cnt_q - CW'(1);
			end
			ST_PHASE: begin
				p16_q <= contrib + held_q + {item_q.rp, 15'd0};
			end
			ST_LOOK: begin
				sine_q <= twpg_pkg::SINE_LUT[sidx];
			end
			ST_FIN: begin
				if (out_free) begin
					sample_q <= res_sat;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== design/tilted_wave_pattern_generator_unit.sv =====
// Top level of the tilted wave pattern generator: configuration registers,
// front, queue and back. Depends on twpg_pkg, twpg_front, twpg_queue, twpg_back.
// The block draws an oriented wave grating. Each input transaction carries one
// pixel coordinate (row, column) and gives exactly one output transaction, a
// signed Q1.15 sample. Input: a transaction is taken at a clock edge with push
// high and full low. Output: while empty is low the oldest result is on
// sample; it is taken at an edge with pop high.
// Configuration is written through cfg_write, cfg_index and cfg_data, one
// register a cycle; the user must write it only while no transaction is in
// flight, as the block does not enforce this. The frame phase is latched on the
// first pixel after reset; later writes of frequency, start phase, tilt or frame
// number do not move it until the next reset. In the back a pixel is taken from
// the queue and passes the multiply steps, the 25-step restoring divider for the
// phase term, then the phase, table and shaping steps; the back takes no new pixel
// until the last result is stored in the result register.
// A two-entry queue sits between front and back, so pushes keep being taken
// while the back works. If the receiver stalls, the finished result waits on
// the port, the back holds its next result, and full rises once the queue
// fills. Reset empties everything, returns registers to their defaults and
// clears the held phase and the saw note.
module tilted_wave_pattern_generator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [11:0]        row,
	input  logic [11:0]        column,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] sample,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data
);

	logic signed [15:0] freq_q;
	logic [15:0]        start_phase_q;
	logic [16:0]        tilt_q;
	logic [1:0]         shape_q;
	logic [12:0]        width_q;
	logic [12:0]        height_q;
	logic [15:0]        frame_q;

	twpg_pkg::cfg_t  cfg;
	twpg_pkg::item_t front_item, back_item;
	logic            q_empty, q_pop;

	// Register writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q        <= 16'sd256;
			start_phase_q <= 16'd0;
			tilt_q        <= 17'd0;
			shape_q       <= twpg_pkg::SHAPE_SINE;
			width_q       <= 13'd640;
			height_q      <= 13'd480;
			frame_q       <= 16'd0;
		end else if (cfg_write) begin
			case (cfg_index)
				twpg_pkg::REG_FREQ:   freq_q        <= cfg_data[15:0];
				twpg_pkg::REG_PHASE:  start_phase_q <= cfg_data[15:0];
				twpg_pkg::REG_TILT:   tilt_q        <= cfg_data;
				twpg_pkg::REG_SHAPE:  shape_q       <= cfg_data[1:0];
				twpg_pkg::REG_WIDTH:  width_q       <= cfg_data[12:0];
				twpg_pkg::REG_HEIGHT: height_q      <= cfg_data[12:0];
				twpg_pkg::REG_FRAME:  frame_q       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Clamp tilt to one turn and the image size to its legal range, then
	// take one off each dimension: the phase spans 0..width-1 and 0..height-1.
	always_comb begin
		cfg.freq        = freq_q;
		cfg.start_phase = start_phase_q;
		cfg.tilt        = (tilt_q > twpg_pkg::ONE_Q16) ? twpg_pkg::ONE_Q16 : tilt_q;
		cfg.shape       = shape_q;
		cfg.frame       = frame_q;
		if (width_q < 13'd2) begin
			cfg.wm1 = twpg_pkg::DW'(1);
		end else if (32'(width_q) > twpg_pkg::MAX_DIM) begin
			cfg.wm1 = twpg_pkg::DW'(twpg_pkg::MAX_DIM - 1);
		end else begin
			cfg.wm1 = twpg_pkg::DW'(width_q - 13'd1);
		end
		if (height_q < 13'd2) begin
			cfg.hm1 = twpg_pkg::DW'(1);
		end else if (32'(height_q) > twpg_pkg::MAX_DIM) begin
			cfg.hm1 = twpg_pkg::DW'(twpg_pkg::MAX_DIM - 1);
		end else begin
			cfg.hm1 = twpg_pkg::DW'(height_q - 13'd1);
		end
	end

	twpg_front u_front (
		.cfg    (cfg),
		.row    (row),
		.column (column),
		.item   (front_item)
	);

	twpg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_item),
		.full    (full),
		.pop     (q_pop),
		.empty   (q_empty),
		.rd_data (back_item)
	);

	twpg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_empty (q_empty),
		.q_data  (back_item),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.sample  (sample)
	);

endmodule

// ===== design/twpg_checker.sv =====
// Port-level checker for the tilted wave pattern generator, bound to the top.
// Depends on tilted_wave_pattern_generator_unit_macros.svh.
`include "tilted_wave_pattern_generator_unit_macros.svh"

module twpg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input logic signed [15:0] sample
);

	// Transactions accepted on the input and not yet taken on the output.
	logic [2:0] inflight_q;
	logic       acc_in, acc_out;

	assign acc_in  = push && !full;
	assign acc_out = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 3'd0;
		end else if (acc_in && !acc_out) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (acc_out && !acc_in) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	`TWPG_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(sample))
	`TWPG_ASSERT_NOW(a_no_invented_result, inflight_q == 3'd0, empty)
	`TWPG_ASSERT_NOW(a_full_means_backlog, full, inflight_q >= 3'd2)
	`TWPG_ASSERT_NOW(a_empty_after_pop, $rose(empty), $past(pop))

endmodule

bind tilted_wave_pattern_generator_unit twpg_checker u_twpg_checker (.*);
